// ----- hw/rtl/bba_pkg.sv -----
// bba_pkg: shared types and constants of the bitmap block allocator
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package bba_pkg;

    localparam int WORD_BITS     = 32;
    localparam int WORD_IDX_BITS = 5;
    localparam int BLK_BITS      = 8;
    localparam int PB_BITS       = 9;
    localparam int STATUS_BITS   = 2;
    localparam int FIELD_REACH   = 256;

    localparam logic [PB_BITS-1:0] PB_RESET = 9'd256;

    // request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd2;

    // outcome of one request, chosen by the controller
    typedef enum logic [1:0] {
        RES_GRANT = 2'd0,
        RES_OK    = 2'd1,
        RES_FULL  = 2'd2,
        RES_BAD   = 2'd3
    } res_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic wr_en;
        logic next_word;
        logic load_out;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic in_range;
        logic bit_set;
        logic found;
        logic last_word;
    } sts_t;

endpackage

// ----- hw/rtl/bba_req_if.sv -----
// bba_req_if: request channel of the bitmap block allocator
// depends on bba_pkg for field widths
interface bba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [bba_pkg::BLK_BITS-1:0] block_number;

    modport source (output valid, output action, output block_number, input ready);
    modport sink   (input valid, input action, input block_number, output ready);
endinterface

// ----- hw/rtl/bba_rsp_if.sv -----
// bba_rsp_if: result channel of the bitmap block allocator
// depends on bba_pkg for field widths
interface bba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::STATUS_BITS-1:0] status;
    logic [bba_pkg::BLK_BITS-1:0]    granted_block;

    modport source (output valid, output status, output granted_block, input ready);
    modport sink   (input valid, input status, input granted_block, output ready);
endinterface

// ----- hw/rtl/bba_ctrl.sv -----
// bba_ctrl: request sequencer of the bitmap block allocator
// depends on bba_pkg; drives bba_dp through cmd_t and reads its sts_t
module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        cmd           = '0;
        cmd.res       = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.action == ACT_FREE && !sts.in_range)
                begin
                    res_next   = RES_BAD;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.action == ACT_FREE)
                begin
                    cmd.wr_en  = sts.bit_set;
                    res_next   = sts.bit_set ? RES_OK : RES_BAD;
                    state_next = S_RESP;
                end
                else if (sts.found)
                begin
                    cmd.wr_en  = 1'b1;
                    res_next   = RES_GRANT;
                    state_next = S_RESP;
                end
                else if (sts.last_word)
                begin
                    res_next   = RES_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= RES_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over an untaken result");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_READ))
        else $error("accepted request not sequenced");

    a_free_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && sts.action == ACT_FREE) |-> (sts.in_range && sts.bit_set))
        else $error("free of an unallocated or out of range block");

    a_alloc_write_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && sts.action == ACT_ALLOC) |-> sts.found)
        else $error("allocate wrote without a free block");
`endif

endmodule

// ----- hw/rtl/bba_dp.sv -----
// bba_dp: bitmap word store, scan logic and result registers of the allocator
// depends on bba_pkg; sequenced by bba_ctrl through cmd_t
module bba_dp #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bba_pkg::PB_BITS-1:0]        cfg_wr_data,
    input  logic                               req_action,
    input  logic [bba_pkg::BLK_BITS-1:0]       req_block_number,
    input  bba_pkg::cmd_t                      cmd,
    output bba_pkg::sts_t                      sts,
    output logic [bba_pkg::STATUS_BITS-1:0]    rsp_status,
    output logic [bba_pkg::BLK_BITS-1:0]       rsp_granted_block
);
    import bba_pkg::*;

    localparam int USE_BLOCKS = (NUM_BLOCKS < FIELD_REACH) ? NUM_BLOCKS : FIELD_REACH;
    localparam int NUM_WORDS  = (USE_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [PB_BITS-1:0]       pb_reg;
    logic                     act_reg;
    logic [BLK_BITS-1:0]      blk_reg;
    logic [WA-1:0]            widx_reg;
    logic [NUM_WORDS-1:0]     vld_reg;
    logic [WORD_BITS-1:0]     mem [NUM_WORDS];
    logic [WORD_BITS-1:0]     mem_q;
    logic                     vld_q;
    logic                     zero_q;
    logic [STATUS_BITS-1:0]   status_reg;
    logic [BLK_BITS-1:0]      granted_reg;

    logic [PB_BITS-1:0]       lim;
    logic [PB_BITS-1:0]       base;
    logic [PB_BITS-1:0]       rem;
    logic [WORD_BITS-1:0]     lim_mask;
    logic [WORD_BITS-1:0]     word;
    logic [WORD_BITS-1:0]     free;
    logic [WORD_IDX_BITS-1:0] fidx;
    logic [WORD_BITS-1:0]     new_word;

    // usable limit and the window of this word that lies below it
    assign lim  = (pb_reg > PB_BITS'(USE_BLOCKS)) ? PB_BITS'(USE_BLOCKS) : pb_reg;
    assign base = PB_BITS'({widx_reg, {WORD_IDX_BITS{1'b0}}});
    assign rem  = (lim > base) ? (lim - base) : '0;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            lim_mask[j] = (PB_BITS'(j) < rem);
        end
    end

    // words never written read as their reset value
    assign word = vld_q ? mem_q : (zero_q ? WORD_BITS'(1) : '0);
    assign free = ~word & lim_mask;

    always_comb
    begin
        fidx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                fidx = WORD_IDX_BITS'(j);
            end
        end
    end

    always_comb
    begin
        if (act_reg == ACT_FREE)
        begin
            new_word = word & ~(WORD_BITS'(1) << blk_reg[WORD_IDX_BITS-1:0]);
        end
        else
        begin
            new_word = word | (WORD_BITS'(1) << fidx);
        end
    end

    assign sts.action    = act_reg;
    assign sts.in_range  = ({1'b0, blk_reg} < lim);
    assign sts.bit_set   = word[blk_reg[WORD_IDX_BITS-1:0]];
    assign sts.found     = |free;
    assign sts.last_word = (rem <= PB_BITS'(WORD_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg  <= PB_RESET;
            vld_reg <= '0;
            vld_q   <= 1'b0;
            zero_q  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pb_reg <= cfg_wr_data;
            end
            if (cmd.wr_en)
            begin
                vld_reg[widx_reg] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                vld_q  <= vld_reg[widx_reg];
                zero_q <= (widx_reg == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[widx_reg] <= new_word;
        end
        if (cmd.rd_en)
        begin
            mem_q <= mem[widx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= req_action;
            blk_reg  <= req_block_number;
            widx_reg <= (req_action == ACT_FREE) ? req_block_number[WORD_IDX_BITS +: WA] : '0;
        end
        else if (cmd.next_word)
        begin
            widx_reg <= WA'(widx_reg + 1'b1);
        end
        if (cmd.load_out)
        begin
            case (cmd.res)
                RES_GRANT:
                begin
                    status_reg  <= ST_OK;
                    granted_reg <= BLK_BITS'({widx_reg, fidx});
                end
                RES_OK:
                begin
                    status_reg  <= ST_OK;
                    granted_reg <= '0;
                end
                RES_FULL:
                begin
                    status_reg  <= ST_FULL;
                    granted_reg <= '0;
                end
                default:
                begin
                    status_reg  <= ST_BAD;
                    granted_reg <= '0;
                end
            endcase
        end
    end

    assign rsp_status        = status_reg;
    assign rsp_granted_block = granted_reg;

endmodule

// ----- hw/rtl/bitmap_block_allocator.sv -----
// sequence: a free reads its map word, evaluates it and loads the result (an out-of-range
// free skips the read); an allocate reads and evaluates one 32-bit map word at a time until
// a free bit or the last word under the limit; flow: one request in flight, the next can
// transfer in the cycle after the result load, which waits while a result is held on rsp
// reset: map reads as block 0 allocated and all others free at once (per-word valid
// bits, no clearing pass); the partition size register returns to 256
// bitmap_block_allocator: top level, first-fit free-block allocator over a bitmap
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ctrl and bba_dp
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp,
    input  logic                        cfg_wr_en,
    input  logic [bba_pkg::PB_BITS-1:0] cfg_wr_data
);
    import bba_pkg::*;

    // command and status between the sequencer and the datapath
    cmd_t cmd;
    sts_t sts;

    // controller: walks each request through read, evaluate (per map word on allocate) and
    // result load, with no read for an out-of-range free; the result sits in an output register
    // so the next request can transfer in while an earlier result still waits on rsp
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: partition size register, 32-bit map words with registered read,
    // lowest-free-bit search inside one word and the result registers
    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .req_action        (req.action),
        .req_block_number  (req.block_number),
        .cmd               (cmd),
        .sts               (sts),
        .rsp_status        (rsp.status),
        .rsp_granted_block (rsp.granted_block)
    );

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench of the bitmap block allocator
// depends on bba_pkg, bba_req_if, bba_rsp_if and bitmap_block_allocator
// a directed table runs first, then random fill, drain and mixed phases under changing partition sizes
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NUM_BLOCKS      = 256;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int IDLE_PCT        = 31;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int DIRECTED_ROWS   = 26;

    // one allocator answer
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [BLK_BITS-1:0]    granted;
    } alloc_answer_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // one line of the directed table; typed answers are checked as written
    typedef struct packed {
        row_kind_t              kind;
        logic                   action;
        logic [BLK_BITS-1:0]    block_number;
        logic [PB_BITS-1:0]     partition;
        logic                   typed;
        logic [STATUS_BITS-1:0] status;
        logic [BLK_BITS-1:0]    granted;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [PB_BITS-1:0] cfg_wr_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow copy of the map and the partition register
    logic [NUM_BLOCKS-1:0] block_map;
    logic [PB_BITS-1:0]    partition_size;

    alloc_answer_t expected_answers[$];

    // answer typed into the table for the request being offered
    logic                   row_typed;
    logic [STATUS_BITS-1:0] row_status;
    logic [BLK_BITS-1:0]    row_granted;

    // set during the long stretch where neither side idles
    logic steady;

    int mismatches;
    int quiet_cycles;
    int requests_seen;
    int success_count;
    int full_count;
    int bad_count;
    int config_writes;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // fresh map: block 0 holds the map, grants start at 1
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_OK,   8'd1},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_OK,   8'd2},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_OK,   8'd3},
        // block 0 may be returned and granted again
        '{ROW_REQ, ACT_FREE,  8'd0,   9'd0,   1'b1, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_OK,   8'd0},
        // return of a free block at the top of the field, then of allocated block 2
        '{ROW_REQ, ACT_FREE,  8'd255, 9'd0,   1'b1, ST_BAD,  8'd0},
        '{ROW_REQ, ACT_FREE,  8'd2,   9'd0,   1'b1, ST_OK,   8'd0},
        // double return
        '{ROW_REQ, ACT_FREE,  8'd2,   9'd0,   1'b1, ST_BAD,  8'd0},
        // zero partition: nothing grantable, nothing returnable
        '{ROW_CFG, ACT_ALLOC, 8'd0,   9'd0,   1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_FULL, 8'd0},
        '{ROW_REQ, ACT_FREE,  8'd0,   9'd0,   1'b1, ST_BAD,  8'd0},
        // limit lowered below allocated block 3
        '{ROW_CFG, ACT_ALLOC, 8'd0,   9'd2,   1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_FULL, 8'd0},
        '{ROW_REQ, ACT_FREE,  8'd3,   9'd0,   1'b1, ST_BAD,  8'd0},
        '{ROW_REQ, ACT_FREE,  8'd1,   9'd0,   1'b1, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b0, ST_OK,   8'd0},
        // register above the field reach; block 3 kept its bit
        '{ROW_CFG, ACT_ALLOC, 8'd0,   9'd511, 1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b0, ST_OK,   8'd0},
        // one-block partition, then back to 256 for a return and an allocate
        '{ROW_CFG, ACT_ALLOC, 8'd0,   9'd1,   1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_FREE,  8'd0,   9'd0,   1'b1, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd255, 9'd0,   1'b1, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b1, ST_FULL, 8'd0},
        '{ROW_CFG, ACT_ALLOC, 8'd0,   9'd256, 1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_FREE,  8'd4,   9'd0,   1'b0, ST_OK,   8'd0},
        '{ROW_REQ, ACT_ALLOC, 8'd0,   9'd0,   1'b0, ST_OK,   8'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // blocks that may be granted or returned under the current register value
    function automatic int usable_blocks();
        int lim;
        lim = partition_size;
        if (lim > NUM_BLOCKS)
            lim = NUM_BLOCKS;
        if (lim > FIELD_REACH)
            lim = FIELD_REACH;
        return lim;
    endfunction

    // first-fit allocate or return against the shadow map
    function automatic alloc_answer_t apply_request(input logic act,
                                                    input logic [BLK_BITS-1:0] blk);
        alloc_answer_t ans;
        int lim;
        lim = usable_blocks();
        ans.granted = '0;
        if (act == ACT_ALLOC)
        begin
            ans.status = ST_FULL;
            for (int i = 0; i < lim; i++)
            begin
                if (!block_map[i])
                begin
                    block_map[i] = 1'b1;
                    ans.granted  = i[BLK_BITS-1:0];
                    ans.status   = ST_OK;
                    break;
                end
            end
        end
        else if (int'(blk) < lim && block_map[blk])
        begin
            block_map[blk] = 1'b0;
            ans.status     = ST_OK;
        end
        else
        begin
            ans.status = ST_BAD;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // offer one request and hold it until the transfer; returns just after a falling edge
    task automatic send_request(input logic act, input logic [BLK_BITS-1:0] blk,
                                input logic typed, input logic [STATUS_BITS-1:0] st,
                                input logic [BLK_BITS-1:0] gb);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.action       = act;
        req_ch.block_number = blk;
        row_typed           = typed;
        row_status          = st;
        row_granted         = gb;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // register write only once every answer is back and the block is idle
    task automatic set_partition(input logic [PB_BITS-1:0] blocks);
        req_ch.valid = 1'b0;
        wait (expected_answers.size() == 0);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = blocks;
        @(negedge clk);
        cfg_wr_en      = 1'b0;
        partition_size = blocks;
        config_writes++;
    endtask

    // result sink: random back-pressure except in the steady stretch
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // scoreboard: check answers, predict on every request transfer, watch for a hang
    always @(posedge clk)
    begin
        alloc_answer_t want;
        logic moved;
        moved = 1'b0;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            moved = 1'b1;
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("answer with nothing pending, status %0d block %0d",
                                          rsp_ch.status, rsp_ch.granted_block));
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.granted_block !== want.granted)
                    report_mismatch($sformatf("granted block %0d, wanted %0d",
                                              rsp_ch.granted_block, want.granted));
                case (want.status)
                    ST_OK:   success_count++;
                    ST_FULL: full_count++;
                    default: bad_count++;
                endcase
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            moved = 1'b1;
            want  = apply_request(req_ch.action, req_ch.block_number);
            if (row_typed)
            begin
                want.status  = row_status;
                want.granted = row_granted;
            end
            expected_answers.push_back(want);
            requests_seen++;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t no transfer for %0d cycles, %0d answers pending",
                     $time, WATCHDOG_CYCLES, expected_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int sent;
        int phase;
        int run_len;
        int alloc_pct;
        int lim;
        int pick;
        int start;
        int slot;
        logic found;
        logic act;
        logic [BLK_BITS-1:0] blk;
        logic [PB_BITS-1:0] new_size;

        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_ALLOC;
        req_ch.block_number = '0;
        row_typed           = 1'b0;
        row_status          = ST_OK;
        row_granted         = '0;
        steady              = 1'b0;
        mismatches          = 0;
        quiet_cycles        = 0;
        requests_seen       = 0;
        success_count       = 0;
        full_count          = 0;
        bad_count           = 0;
        config_writes       = 0;
        block_map           = '0;
        block_map[0]        = 1'b1;
        partition_size      = PB_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                set_partition(directed_rows[r].partition);
            else
                send_request(directed_rows[r].action, directed_rows[r].block_number,
                             directed_rows[r].typed, directed_rows[r].status,
                             directed_rows[r].granted);
        end

        // random phases: fill, drain or mixed, each under a new or kept partition size
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == 0 || $urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    new_size = PB_BITS'($urandom_range(16, 1));
                else if (pick < 50)
                    case ($urandom_range(3))
                        0:       new_size = 9'd0;
                        1:       new_size = 9'd1;
                        2:       new_size = 9'd256;
                        default: new_size = 9'd511;
                    endcase
                else if (pick < 75)
                    new_size = PB_BITS'($urandom_range(255, 17));
                else
                    new_size = PB_BITS'($urandom_range(511, 0));
                set_partition(new_size);
            end

            // the fifth phase runs with no idling on either side
            steady = (phase == 4);
            case ($urandom_range(2))
                0:       alloc_pct = 85;
                1:       alloc_pct = 20;
                default: alloc_pct = 50;
            endcase
            run_len = $urandom_range(120, 40);

            repeat (run_len)
            begin
                act = ($urandom_range(99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
                blk = BLK_BITS'($urandom_range(255));   // ignored on allocate
                if (act == ACT_FREE)
                begin
                    lim  = usable_blocks();
                    pick = $urandom_range(99);
                    if (pick < 70)
                    begin
                        // mostly return a block that is allocated and in range
                        start = $urandom_range(255);
                        found = 1'b0;
                        for (int k = 0; k < FIELD_REACH && !found; k++)
                        begin
                            slot = (start + k) % FIELD_REACH;
                            if (slot < lim && block_map[slot])
                            begin
                                blk   = BLK_BITS'(slot);
                                found = 1'b1;
                            end
                        end
                    end
                    else if (pick >= 85 && lim < FIELD_REACH)
                    begin
                        blk = BLK_BITS'($urandom_range(255, lim));
                    end
                end
                send_request(act, blk, 1'b0, ST_OK, '0);
                sent++;
            end
            phase++;
        end
        steady = 1'b0;

        // let every answer come back, then a little longer for strays
        req_ch.valid = 1'b0;
        wait (expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d partition settings: %0d succeeded,",
                 requests_seen, config_writes, success_count);
        $display("%0d found no free block, %0d rejected returns; %0d mismatches",
                 full_count, bad_count, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bba_pkg.sv
hw/rtl/bba_req_if.sv
hw/rtl/bba_rsp_if.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dp.sv
hw/rtl/bitmap_block_allocator.sv
dv/tb_top.sv
